>>> hdl/itoa_pkg.sv
`timescale 1ns / 1ps
// Package for the signed integer to decimal ASCII converter.
// Widths, character codes, power-of-ten tables and the queue entry type.
// No dependencies.
package itoa_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 6;
  localparam int WIDE_W     = 36;
  localparam int DIGITS     = 10;
  localparam int POS_W      = 4;
  localparam int DIGIT_W    = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = 2;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_NINE  = CHAR_W'(57);

  typedef logic [DIGITS:0][WIDE_W-1:0]                   pow_tbl_t;
  typedef logic [DIGITS-1:0][DIGITS-1:0][WIDE_W-1:0]     mult_tbl_t;

  function automatic pow_tbl_t build_pow();
    pow_tbl_t    t;
    logic [WIDE_W-1:0] p;
    p = WIDE_W'(1);
    for (int k = 0; k <= DIGITS; k++) begin
      t[k] = p;
      p = WIDE_W'(p * 10);
    end
    return t;
  endfunction

  localparam pow_tbl_t POW10 = build_pow();

  // MULT_TBL[k][d] = d * 10^k
  function automatic mult_tbl_t build_mult();
    mult_tbl_t t;
    for (int k = 0; k < DIGITS; k++) begin
      for (int d = 0; d < DIGITS; d++) begin
        t[k][d] = WIDE_W'(POW10[k] * d);
      end
    end
    return t;
  endfunction

  localparam mult_tbl_t MULT_TBL = build_mult();

  typedef struct packed {
    logic                neg;
    logic [VALUE_W-1:0]  mag;
    logic [POS_W-1:0]    top;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

>>> hdl/itoa_in_if.sv
`timescale 1ns / 1ps
// Input channel: one signed integer per beat.
// Depends on itoa_pkg.
interface itoa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [itoa_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> hdl/itoa_out_if.sv
`timescale 1ns / 1ps
// Output channel: one ASCII character per beat, last marks end of text.
// Depends on itoa_pkg.
interface itoa_out_if;
  logic                           valid;
  logic                           ready;
  logic [itoa_pkg::CHAR_W-1:0]    character;
  logic                           last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

>>> hdl/itoa_front.sv
`timescale 1ns / 1ps
// Front end: takes input beats, forms sign and magnitude, counts digits.
// Depends on itoa_pkg and itoa_in_if.
module itoa_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  itoa_in_if.sink              in_i,
  input  itoa_pkg::queue_stat_t qstat_i,
  output logic                 push_o,
  output itoa_pkg::job_t       job_o
);

  logic                           valid_q, valid_d;
  logic                           neg_q, neg_d;
  logic [itoa_pkg::VALUE_W-1:0]   mag_q, mag_d;
  logic                           take;
  logic [itoa_pkg::DIGITS-2:0]    ge;
  logic [itoa_pkg::POS_W-1:0]     top;

  assign push_o     = valid_q && !qstat_i.full;
  assign in_i.ready = !valid_q || !qstat_i.full;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d = 1'b1;
      neg_d   = in_i.value[itoa_pkg::VALUE_W-1];
      mag_d   = in_i.value[itoa_pkg::VALUE_W-1] ? (~in_i.value + 1'b1) : in_i.value;
    end
  end

  // digit count minus one = number of powers 10^1..10^9 not above mag
  always_comb begin
    top = '0;
    for (int k = 1; k < itoa_pkg::DIGITS; k++) begin
      ge[k-1] = {{(itoa_pkg::WIDE_W-itoa_pkg::VALUE_W){1'b0}}, mag_q} >= itoa_pkg::POW10[k];
      top = top + itoa_pkg::POS_W'(ge[k-1]);
    end
  end

  assign job_o.neg = neg_q;
  assign job_o.mag = mag_q;
  assign job_o.top = top;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
  end

endmodule

>>> hdl/itoa_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of conversion jobs between front and back end.
// Depends on itoa_pkg.
module itoa_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  itoa_pkg::job_t        job_i,
  input  logic                  pop_i,
  output itoa_pkg::job_t        job_o,
  output itoa_pkg::queue_stat_t stat_o
);

  itoa_pkg::job_t                   mem_q [itoa_pkg::QUEUE_DEPTH];
  logic [itoa_pkg::QPTR_W-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [itoa_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign stat_o.full  = cnt_q == itoa_pkg::QCNT_W'(itoa_pkg::QUEUE_DEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign job_o        = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + itoa_pkg::QCNT_W'(do_push) - itoa_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

>>> hdl/itoa_back.sv
`timescale 1ns / 1ps
// Back end: emits sign then one decimal digit per beat, most significant first.
// Depends on itoa_pkg and itoa_out_if.
module itoa_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  itoa_pkg::queue_stat_t qstat_i,
  input  itoa_pkg::job_t        job_i,
  output logic                  pop_o,
  itoa_out_if.source            out_o
);

  logic                           busy_q, busy_d;
  logic                           sign_q, sign_d;
  logic [itoa_pkg::VALUE_W-1:0]   rem_q, rem_d;
  logic [itoa_pkg::POS_W-1:0]     pos_q, pos_d;
  logic                           oval_q, oval_d;
  logic [itoa_pkg::CHAR_W-1:0]    char_q, char_d;
  logic                           last_q, last_d;
  logic                           adv;
  logic [itoa_pkg::DIGITS-2:0]    ge;
  logic [itoa_pkg::DIGIT_W-1:0]   digit;
  logic [itoa_pkg::WIDE_W-1:0]    sub;

  assign out_o.valid     = oval_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

  assign adv   = busy_q && (!oval_q || out_o.ready);
  assign pop_o = !busy_q && !qstat_i.empty;

  // digit = number of multiples d*10^pos (d = 1..9) not above remainder
  always_comb begin
    digit = '0;
    for (int d = 1; d < itoa_pkg::DIGITS; d++) begin
      ge[d-1] = {{(itoa_pkg::WIDE_W-itoa_pkg::VALUE_W){1'b0}}, rem_q}
                >= itoa_pkg::MULT_TBL[pos_q][d];
      digit = digit + itoa_pkg::DIGIT_W'(ge[d-1]);
    end
    sub = itoa_pkg::MULT_TBL[pos_q][digit];
  end

  always_comb begin
    busy_d = busy_q;
    sign_d = sign_q;
    rem_d  = rem_q;
    pos_d  = pos_q;
    oval_d = oval_q && !out_o.ready;
    char_d = char_q;
    last_d = last_q;
    if (pop_o) begin
      busy_d = 1'b1;
      sign_d = job_i.neg;
      rem_d  = job_i.mag;
      pos_d  = job_i.top;
    end else if (adv) begin
      oval_d = 1'b1;
      if (sign_q) begin
        sign_d = 1'b0;
        char_d = itoa_pkg::CHAR_MINUS;
        last_d = 1'b0;
      end else begin
        char_d = itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(digit);
        last_d = pos_q == '0;
        rem_d  = rem_q - sub[itoa_pkg::VALUE_W-1:0];
        pos_d  = pos_q - 1'b1;
        busy_d = pos_q != '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      oval_q <= 1'b0;
      sign_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      busy_q <= busy_d;
      oval_q <= oval_d;
      sign_q <= sign_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    char_q <= char_d;
    last_q <= last_d;
  end

endmodule

>>> hdl/signed_int_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// Channel  Dir  Modport       Payload
// in_i     in   itoa_in_if    value[31:0] signed
// out_o    out  itoa_out_if   character[5:0], last
//
// A number of n characters (digits plus optional '-') holds the digit unit
// for a load step, then one character per cycle while out_o is not stalled.
// Each digit comes from nine parallel compares against d*10^pos.
// Input passes the front register, the two-entry queue parting front and back end
// and the back-end registers. Reset is asynchronous, active low; no clearing pass.
// Top level: front end, job queue, digit back end.
// Depends on itoa_pkg, itoa_in_if, itoa_out_if, itoa_front, itoa_queue, itoa_back.
module signed_int_to_decimal_ascii_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  itoa_in_if.sink    in_i,
  itoa_out_if.source out_o
);

  itoa_pkg::queue_stat_t qstat;
  itoa_pkg::job_t        push_job;
  itoa_pkg::job_t        head_job;
  logic                  push;
  logic                  pop;

  itoa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .qstat_i (qstat),
    .push_o  (push),
    .job_o   (push_job)
  );

  itoa_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (qstat)
  );

  itoa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qstat_i (qstat),
    .job_i   (head_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  a_queue_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty))
    else $error("queue both full and empty");

  a_char_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.character == itoa_pkg::CHAR_MINUS ||
                     (out_o.character >= itoa_pkg::CHAR_ZERO &&
                      out_o.character <= itoa_pkg::CHAR_NINE)))
    else $error("bad character code");

  a_last_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last |-> out_o.character != itoa_pkg::CHAR_MINUS)
    else $error("sign marked last");

  a_pop_push_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule
